@@ hw/rtl/limit_order_book_matcher_core_assert.svh @@
// assertion macros for the order book matcher
`ifndef LIMIT_ORDER_BOOK_MATCHER_CORE_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_CORE_ASSERT_SVH
`ifndef SYNTH
`define LOBM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label");
`define LOBM_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: label");
`else
`define LOBM_ASSERT(label, clk, rst, prop)
`define LOBM_ASSERT_NR(label, clk, prop)
`endif
`endif

@@ hw/rtl/lobm_pkg.sv @@
// shared types, constants and codes of the order book matcher
package lobm_pkg;
   localparam int BookDepth  = 32;
   localparam int PriceBits  = 16;
   localparam int QtyBits    = 16;
   localparam int IdBits     = 16;
   localparam int TotalBits  = 21;
   localparam int IdxBits    = $clog2(BookDepth);
   localparam int CntBits    = $clog2(BookDepth + 1);

   typedef enum logic [2:0] {
      REQ_BUY = 3'd0, REQ_SELL = 3'd1, REQ_MODIFY = 3'd2, REQ_CANCEL = 3'd3,
      REQ_PRINT = 3'd4
   } req_code_type;

   localparam logic [1:0] KIND_TRADE  = 2'd0;
   localparam logic [1:0] KIND_SELL   = 2'd1;
   localparam logic [1:0] KIND_BUY    = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   typedef struct packed {
      logic [2:0]           req_type;
      logic                 modify_side;
      logic                 good_for_day;
      logic [IdBits-1:0]    order_id;
      logic [PriceBits-1:0] limit_price;
      logic [QtyBits-1:0]   order_qty;
   } req_type_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [IdBits-1:0]    resting_id;
      logic [PriceBits-1:0] resting_price;
      logic [IdBits-1:0]    incoming_id;
      logic [PriceBits-1:0] incoming_price;
      logic [QtyBits-1:0]   fill_qty;
      logic [PriceBits-1:0] level_price;
      logic [TotalBits-1:0] level_total;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic                 side;
      logic [IdBits-1:0]    id;
      logic [PriceBits-1:0] price;
      logic [QtyBits-1:0]   qty;
   } entry_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // latch request
      logic scan;        // evaluate book with current working order / bound
      logic remove_id;   // remove entry found by id
      logic fill;        // apply fill on best entry, drive trade item
      logic rest;        // append remainder
      logic reject;      // drive reject item
      logic level;       // drive level item, step bound
      logic print_side;  // side for print scan (1 sell, 0 buy)
      logic print_init;  // reset print bound
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [2:0] req_type;
      logic       valid_order;  // price, qty nonzero
      logic       id_found;
      logic       best_found;   // a matching entry exists
      logic       qty_zero;     // remaining quantity is zero
      logic       gfd;
      logic       full;
      logic       level_found;
      logic       more_level;   // a level exists below the current print bound
   } stat_type;
endpackage

@@ hw/rtl/lobm_stream_if.sv @@
// valid/ready channel interface
interface lobm_stream_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/limit_order_book_matcher_core.sv @@
// top level of the order book matcher
//  channel | dir | payload              | handshake
//  req     | in  | order request item   | valid/ready
//  rsp     | out | trade/level/reject   | valid/ready
// each fill and each print level waits for a book scan that is registered first.
// results leave through a one-item register, so a result is shown once the next
// item of the same request or the request's end is known; a new request waits
// until the final result has left, and a stalled receiver stalls the fills.
// reset empties the book at once; no clearing pass.
module limit_order_book_matcher_core (
   input logic clock,
   input logic reset,
   lobm_stream_if.sink   req,
   lobm_stream_if.source rsp
);
   lobm_pkg::cmd_type  cmd;
   lobm_pkg::stat_type stat;
   lobm_pkg::rsp_type  item;
   logic c_req_ready, c_valid, c_last, b_ready, b_idle, c_ready;

   // the controller waits at idle until the held item is gone
   assign req.ready = c_req_ready && b_idle;
   assign c_ready   = b_ready;

   lobm_ctrl u_ctrl (
      .clock, .reset, .req_valid(req.valid && b_idle), .req_ready(c_req_ready),
      .rsp_valid(c_valid), .rsp_ready(c_ready), .rsp_last(c_last), .stat, .cmd
   );
   lobm_datapath u_dp (
      .clock, .reset, .req_in(req.data), .cmd, .stat, .item_out(item)
   );
   lobm_pkg::rsp_type item_l;
   always_comb begin
      item_l = item; item_l.last = c_last;
   end
   lobm_out_buf u_buf (
      .clock, .reset, .in_valid(c_valid), .in_ready(b_ready), .in_item(item_l),
      .flush(c_req_ready || c_last), .idle(b_idle), .rsp
   );
endmodule

@@ hw/rtl/lobm_datapath.sv @@
// book storage, scans, fills and result formatting
module lobm_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  lobm_pkg::req_type_type req_in,
   input  lobm_pkg::cmd_type     cmd,
   output lobm_pkg::stat_type    stat,
   output lobm_pkg::rsp_type     item_out
);
   lobm_pkg::entry_type            book_ff [lobm_pkg::BookDepth];
   logic [lobm_pkg::CntBits-1:0]   count_ff;
   lobm_pkg::req_type_type         req_ff;
   logic                           side_ff;
   logic [lobm_pkg::QtyBits-1:0]   qty_ff;
   // registered scan results
   logic                           best_ok_ff, id_ok_ff, lvl_ok_ff;
   logic [lobm_pkg::IdxBits-1:0]   best_ff, idx_ff;
   logic [lobm_pkg::PriceBits-1:0] lvl_ff, bound_ff;
   logic                           bound_top_ff;

   // combinational scan over the book
   logic                           b_ok, i_ok, l_ok;
   logic [lobm_pkg::IdxBits-1:0]   b_idx, i_idx;
   logic [lobm_pkg::PriceBits-1:0] l_pr;
   logic [lobm_pkg::TotalBits-1:0] l_tot;
   logic                           live;
   logic                           scan_side;
   // per-entry candidates, reduced pairwise so the earlier entry wins a tie
   logic                           b_c_ok  [lobm_pkg::BookDepth];
   logic [lobm_pkg::IdxBits-1:0]   b_c_idx [lobm_pkg::BookDepth];
   logic [lobm_pkg::PriceBits-1:0] b_c_pr  [lobm_pkg::BookDepth];
   logic                           l_c_ok  [lobm_pkg::BookDepth];
   logic [lobm_pkg::PriceBits-1:0] l_c_pr  [lobm_pkg::BookDepth];
   logic [lobm_pkg::TotalBits-1:0] t_c     [lobm_pkg::BookDepth];

   always_comb begin
      i_ok = 1'b0; i_idx = '0; live = 1'b0;
      scan_side = cmd.print_side;
      for (int i = 0; i < lobm_pkg::BookDepth; i++) begin
         live = (i < int'(count_ff));
         if (live && !i_ok && book_ff[i].id == req_ff.order_id) begin
            i_ok = 1'b1; i_idx = lobm_pkg::IdxBits'(i);
         end
         b_c_ok[i]  = live && book_ff[i].side != side_ff &&
                      (side_ff ? book_ff[i].price >= req_ff.limit_price
                               : book_ff[i].price <= req_ff.limit_price);
         b_c_idx[i] = lobm_pkg::IdxBits'(i);
         b_c_pr[i]  = book_ff[i].price;
         l_c_ok[i]  = live && book_ff[i].side == scan_side &&
                      (bound_top_ff || book_ff[i].price < bound_ff);
         l_c_pr[i]  = book_ff[i].price;
      end
      // best match and highest level below the bound, as a tree
      for (int s = 1; s < lobm_pkg::BookDepth; s = s * 2)
         for (int i = 0; i + s < lobm_pkg::BookDepth; i = i + 2 * s) begin
            if (b_c_ok[i+s] && (!b_c_ok[i] ||
                (side_ff ? b_c_pr[i+s] > b_c_pr[i] : b_c_pr[i+s] < b_c_pr[i]))) begin
               b_c_ok[i] = 1'b1; b_c_idx[i] = b_c_idx[i+s]; b_c_pr[i] = b_c_pr[i+s];
            end
            if (l_c_ok[i+s] && (!l_c_ok[i] || l_c_pr[i+s] > l_c_pr[i])) begin
               l_c_ok[i] = 1'b1; l_c_pr[i] = l_c_pr[i+s];
            end
         end
      b_ok = b_c_ok[0]; b_idx = b_c_idx[0];
      l_ok = l_c_ok[0]; l_pr = l_c_pr[0];
   end
   // level total uses the registered level price, summed as a tree
   always_comb begin
      for (int i = 0; i < lobm_pkg::BookDepth; i++)
         t_c[i] = (i < int'(count_ff) && book_ff[i].side == scan_side &&
                   book_ff[i].price == lvl_ff) ? lobm_pkg::TotalBits'(book_ff[i].qty) : '0;
      for (int s = 1; s < lobm_pkg::BookDepth; s = s * 2)
         for (int i = 0; i + s < lobm_pkg::BookDepth; i = i + 2 * s)
            t_c[i] = t_c[i] + t_c[i+s];
      l_tot = t_c[0];
   end

   logic [lobm_pkg::QtyBits-1:0] best_qty, fq;
   assign best_qty = book_ff[best_ff].qty;
   assign fq = (best_qty < qty_ff) ? best_qty : qty_ff;

   // removal index: by id or the exhausted best
   logic                         do_rm;
   logic [lobm_pkg::IdxBits-1:0] rm_idx;
   assign do_rm  = (cmd.remove_id && id_ok_ff) || (cmd.fill && best_qty == fq);
   assign rm_idx = cmd.remove_id ? idx_ff : best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         if (do_rm) count_ff <= count_ff - 1'b1;
         else if (cmd.rest && 32'(count_ff) < lobm_pkg::BookDepth)
            count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_in;
         side_ff <= (req_in.req_type == lobm_pkg::REQ_MODIFY) ? req_in.modify_side
                                                              : req_in.req_type[0];
         qty_ff  <= req_in.order_qty;
      end
      if (cmd.scan) begin
         best_ok_ff <= b_ok; best_ff <= b_idx;
         id_ok_ff <= i_ok; idx_ff <= i_idx;
         lvl_ok_ff <= l_ok; lvl_ff <= l_pr;
      end
      if (cmd.print_init) bound_top_ff <= 1'b1;
      if (cmd.level) begin
         bound_top_ff <= 1'b0; bound_ff <= lvl_ff;
      end
      if (cmd.fill) qty_ff <= qty_ff - fq;
      // partial fill keeps the entry, an exhausted one is shifted out
      if (cmd.fill && !do_rm) book_ff[best_ff].qty <= best_qty - fq;
      if (do_rm)
         for (int i = 0; i < lobm_pkg::BookDepth - 1; i++)
            if (i >= int'(rm_idx)) book_ff[i] <= book_ff[i+1];
      if (cmd.rest && 32'(count_ff) < lobm_pkg::BookDepth)
         book_ff[count_ff[lobm_pkg::IdxBits-1:0]] <= '{side_ff, req_ff.order_id,
                                                      req_ff.limit_price, qty_ff};
   end

   // result item formatting
   always_comb begin
      item_out = '0;
      if (cmd.fill) begin
         item_out.kind = lobm_pkg::KIND_TRADE;
         item_out.resting_id = book_ff[best_ff].id;
         item_out.resting_price = book_ff[best_ff].price;
         item_out.incoming_id = req_ff.order_id;
         item_out.incoming_price = req_ff.limit_price;
         item_out.fill_qty = fq;
      end else if (cmd.reject) begin
         item_out.kind = lobm_pkg::KIND_REJECT;
         item_out.incoming_id = req_ff.order_id;
         item_out.incoming_price = req_ff.limit_price;
         item_out.fill_qty = qty_ff;
      end else if (cmd.level) begin
         item_out.kind = cmd.print_side ? lobm_pkg::KIND_SELL : lobm_pkg::KIND_BUY;
         item_out.level_price = lvl_ff;
         item_out.level_total = l_tot;
      end
   end

   assign stat.req_type    = req_ff.req_type;
   assign stat.valid_order = req_ff.limit_price != '0 && req_ff.order_qty != '0;
   assign stat.id_found    = id_ok_ff;
   assign stat.best_found  = best_ok_ff;
   assign stat.qty_zero    = qty_ff == '0;
   assign stat.gfd         = req_ff.good_for_day ||
                             req_ff.req_type == lobm_pkg::REQ_MODIFY;
   assign stat.full        = 32'(count_ff) >= lobm_pkg::BookDepth;
   assign stat.level_found = lvl_ok_ff;
   assign stat.more_level  = l_ok;
endmodule

@@ hw/rtl/lobm_ctrl.sv @@
// sequencing of match, cancel and print work
`include "limit_order_book_matcher_core_assert.svh"
module lobm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_last,
   input  lobm_pkg::stat_type stat,
   output lobm_pkg::cmd_type  cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_ID, S_DECIDE, S_SCAN_BEST, S_FILL, S_TAIL, S_REJECT,
      S_PSCAN, S_LEVEL
   } state_type;
   state_type state_ff, state_in;
   logic      pside_ff, pside_in;

   always_comb begin
      state_in = state_ff; pside_in = pside_ff;
      cmd = '0; cmd.print_side = pside_ff;
      req_ready = 1'b0; rsp_valid = 1'b0; rsp_last = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin cmd.load = 1'b1; state_in = S_SCAN_ID; end
         end
         S_SCAN_ID: begin cmd.scan = 1'b1; state_in = S_DECIDE; end
         S_DECIDE: begin
            state_in = S_IDLE;
            case (stat.req_type)
               lobm_pkg::REQ_BUY, lobm_pkg::REQ_SELL:
                  if (stat.valid_order && !stat.id_found) state_in = S_SCAN_BEST;
               lobm_pkg::REQ_MODIFY:
                  if (stat.valid_order && stat.id_found) begin
                     cmd.remove_id = 1'b1; state_in = S_SCAN_BEST;
                  end
               lobm_pkg::REQ_CANCEL: cmd.remove_id = 1'b1;
               lobm_pkg::REQ_PRINT: begin
                  cmd.print_init = 1'b1; pside_in = 1'b1; state_in = S_PSCAN;
               end
               default: ;
            endcase
         end
         S_SCAN_BEST: begin cmd.scan = 1'b1; state_in = S_FILL; end
         S_FILL: begin
            if (stat.best_found && !stat.qty_zero) begin
               rsp_valid = 1'b1;
               if (rsp_ready) begin cmd.fill = 1'b1; state_in = S_SCAN_BEST; end
            end else state_in = S_TAIL;
         end
         S_TAIL: begin
            state_in = S_IDLE;
            if (!stat.qty_zero && stat.gfd) begin
               if (stat.full) state_in = S_REJECT;
               else cmd.rest = 1'b1;
            end
         end
         S_REJECT: begin
            cmd.reject = 1'b1; rsp_valid = 1'b1; rsp_last = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         S_PSCAN: begin
            cmd.scan = 1'b1;
            state_in = S_LEVEL;
         end
         S_LEVEL: begin
            if (stat.level_found) begin
               cmd.level = 1'b1; rsp_valid = 1'b1;
               if (rsp_ready) state_in = S_PSCAN;
               else cmd.level = 1'b0;
            end else if (pside_ff) begin
               pside_in = 1'b0; cmd.print_init = 1'b1; state_in = S_PSCAN;
            end else state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; pside_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pside_ff <= pside_in;
      end
   end

   `LOBM_ASSERT(a_ready_idle, clock, reset, req_ready |-> state_ff == S_IDLE)
   `LOBM_ASSERT(a_rsp_not_idle, clock, reset, rsp_valid |-> state_ff != S_IDLE)
   `LOBM_ASSERT(a_one_write, clock, reset, $onehot0({cmd.fill, cmd.rest, cmd.remove_id}))
endmodule

@@ hw/rtl/lobm_out_buf.sv @@
// result register with last-marking by one-item lookahead
module lobm_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  lobm_pkg::rsp_type in_item,
   input  logic              flush,
   output logic              idle,
   lobm_stream_if.source     rsp
);
   // one held item; it leaves once the next item is offered or the request has ended
   lobm_pkg::rsp_type hold_ff;
   logic              full_ff, done_ff;
   assign rsp.valid = full_ff && (done_ff || in_valid);
   assign rsp.data  = hold_ff;
   assign in_ready  = !full_ff || (rsp.valid && rsp.ready);
   assign idle      = !full_ff;
   logic take;
   assign take = in_valid && in_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         if (take) begin
            full_ff <= 1'b1; done_ff <= 1'b0;
         end else if (rsp.valid && rsp.ready) full_ff <= 1'b0;
         else if (full_ff && flush) done_ff <= 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (take) hold_ff <= in_item;
      else if (full_ff && flush && !done_ff) hold_ff.last <= 1'b1;
   end
endmodule
